FILE: rtl/geodetic_slant_range_defines.svh
// ----------------------------------------------------------------------------
// geodetic slant range assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GEODETIC_SLANT_RANGE_DEFINES_SVH
`define GEODETIC_SLANT_RANGE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define GSR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("geodetic slant range check failed");

// expression must never be true out of reset
`define GSR_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("geodetic slant range forbidden condition");

`endif

FILE: rtl/gsr_pkg.sv
// ----------------------------------------------------------------------------
// gsr_pkg
// constants, types and elaboration-time tables for the slant range pipeline
// ----------------------------------------------------------------------------
package gsr_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int MAX_STAGES = 32;
	localparam int NEWTON_STEPS = 6;
	localparam int LAT_FIXED = 86;
	localparam logic [63:0] SEMI_MAJOR_CM = 64'd637813700;
	localparam logic [63:0] ECC2_Q40 = 64'd7360548724;
	localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
	localparam logic [63:0] ONE_Q58 = 64'd1 << 58;
	localparam logic [63:0] THREE_Q60 = 64'd3 << 60;
	localparam logic [63:0] GAIN_SEED_Q60 = ONE_Q60 / 5 * 3;
	localparam logic [32:0] RANGE_TOP = 33'd1300000000;

	typedef struct packed {
		logic [63:0] cl;
		logic [63:0] sl;
		logic [63:0] co;
		logic [63:0] so;
		logic [24:0] h;
	} trig_t;

	typedef struct packed {
		trig_t tr;
		logic [63:0] v;
		logic [63:0] y;
	} nsd_t;

	typedef struct packed {
		trig_t tr;
		logic [63:0] n;
	} nt_t;

	typedef logic [2:0][63:0] pos_t;

	function automatic logic [63:0] mulshr_f(input logic [63:0] x, input logic [63:0] y,
			input int s);
		logic [127:0] pr;
		pr = {64'b0, x} * {64'b0, y};
		pr = pr + (128'd1 << (s - 1));
		return pr[s +: 64];
	endfunction

	// restoring long division, only evaluated while building constant tables
	function automatic logic [63:0] udiv_f(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] inv_sqrt_f(input logic [63:0] v, input logic [63:0] y0);
		logic [63:0] y, y2, gy, t;
		y = y0;
		for (int n = 0; n < NEWTON_STEPS; n++) begin
			y2 = mulshr_f(y, y, 60);
			gy = mulshr_f(v, y2, 60);
			t = (gy >= THREE_Q60) ? 64'd0 : THREE_Q60 - gy;
			y = mulshr_f(y, t, 61);
		end
		return y;
	endfunction

	function automatic logic [63:0] cordic_gain(input int n);
		logic [63:0] g;
		g = ONE_Q60;
		for (int i = 0; i < n && i < MAX_STAGES; i++) begin
			g = g + (g >> (2 * i));
		end
		return inv_sqrt_f(g, GAIN_SEED_Q60);
	endfunction

	function automatic logic [63:0] atan_series(input int i);
		logic [63:0] sum, term;
		sum = '0;
		for (int k = 0; i * (2 * k + 1) <= 58; k++) begin
			term = udiv_f(64'd1 << (58 - i * (2 * k + 1)), 64'(2 * k + 1));
			sum = k[0] ? sum - term : sum + term;
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_third();
		logic [63:0] sum, term, p;
		int k;
		sum = '0;
		p = 64'd3;
		k = 0;
		while (p <= ONE_Q58) begin
			term = udiv_f(ONE_Q58, p * 64'(2 * k + 1));
			sum = k[0] ? sum - term : sum + term;
			p = p * 64'd9;
			k++;
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_q58(input int i);
		return (i == 0) ? atan_series(1) + atan_third() : atan_series(i);
	endfunction

	function automatic int gsr_latency(input int n);
		return n + LAT_FIXED;
	endfunction

endpackage

FILE: rtl/gsr_mul.sv
// ----------------------------------------------------------------------------
// gsr_mul
// two-stage 64x64 multiplier from 32x32 partials, rounded right shift
// ----------------------------------------------------------------------------
module gsr_mul #(
	parameter int SHIFT = 60,
	parameter bit SGN = 1'b0,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_v,
	input  logic [63:0]   x,
	input  logic [63:0]   y,
	input  logic [SW-1:0] side_in,
	output logic          out_v,
	output logic [63:0]   p,
	output logic [SW-1:0] side_out
);
	localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);

	logic [63:0] xa, ya, ll, lh, hl, hh;
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic neg_s1, v_s1, v_s2;
	logic [SW-1:0] side_s1, side_s2;
	logic [127:0] full;
	logic [63:0] res, mres, p_s2;

	assign xa = (SGN && x[63]) ? 64'(-x) : x;
	assign ya = (SGN && y[63]) ? 64'(-y) : y;
	assign ll = xa[31:0] * ya[31:0];
	assign lh = xa[31:0] * ya[63:32];
	assign hl = xa[63:32] * ya[31:0];
	assign hh = xa[63:32] * ya[63:32];

	always_ff @(posedge clk) begin
		ll_s1 <= ll;
		lh_s1 <= lh;
		hl_s1 <= hl;
		hh_s1 <= hh;
		neg_s1 <= SGN && (x[63] ^ y[63]);
		side_s1 <= side_in;
	end

	assign full = {hh_s1, 64'b0} + {32'b0, lh_s1, 32'b0} + {32'b0, hl_s1, 32'b0}
		+ {64'b0, ll_s1} + RND;
	assign res = full[SHIFT+63:SHIFT];
	assign mres = SGN ? {2'b00, res[61:0]} : res;

	always_ff @(posedge clk) begin
		p_s2 <= neg_s1 ? 64'(-mres) : mres;
		side_s2 <= side_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	assign out_v = v_s2;
	assign p = p_s2;
	assign side_out = side_s2;
endmodule

FILE: rtl/gsr_sincos.sv
// ----------------------------------------------------------------------------
// gsr_sincos
// two-lane pipelined cordic: quadrant fold, rotation stages, sign fix
// ----------------------------------------------------------------------------
module gsr_sincos import gsr_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF,
	parameter int SW = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_v,
	input  logic signed [63:0] a_z,
	input  logic signed [63:0] b_z,
	input  logic [SW-1:0]      side_in,
	output logic               out_v,
	output logic signed [63:0] a_cos,
	output logic signed [63:0] a_sin,
	output logic signed [63:0] b_cos,
	output logic signed [63:0] b_sin,
	output logic [SW-1:0]      side_out
);
	localparam logic signed [63:0] HALF_PI = atan_q58(0) << 1;
	localparam logic signed [63:0] NEG_HALF_PI = -HALF_PI;
	localparam logic signed [63:0] PI = atan_q58(0) << 2;
	localparam logic signed [63:0] K = cordic_gain(STAGES);

	logic signed [63:0] x_s [2][STAGES+1];
	logic signed [63:0] y_s [2][STAGES+1];
	logic signed [63:0] z_s [2][STAGES+1];
	logic neg_s [2][STAGES+1];
	logic v_s [STAGES+2];
	logic [SW-1:0] side_s [STAGES+2];
	logic signed [63:0] zin [2];
	logic signed [63:0] cos_s [2];
	logic signed [63:0] sin_s [2];

	assign zin[0] = a_z;
	assign zin[1] = b_z;

	for (genvar l = 0; l < 2; l++) begin : g_lane
		always_ff @(posedge clk) begin
			x_s[l][0] <= K;
			y_s[l][0] <= '0;
			if (zin[l] > HALF_PI) begin
				z_s[l][0] <= zin[l] - PI;
				neg_s[l][0] <= 1'b1;
			end else if (zin[l] < NEG_HALF_PI) begin
				z_s[l][0] <= zin[l] + PI;
				neg_s[l][0] <= 1'b1;
			end else begin
				z_s[l][0] <= zin[l];
				neg_s[l][0] <= 1'b0;
			end
		end

		for (genvar i = 0; i < STAGES; i++) begin : g_stage
			localparam logic signed [63:0] AT = atan_q58(i);
			always_ff @(posedge clk) begin
				neg_s[l][i+1] <= neg_s[l][i];
				if (z_s[l][i] >= 0) begin
					x_s[l][i+1] <= x_s[l][i] - (y_s[l][i] >>> i);
					y_s[l][i+1] <= y_s[l][i] + (x_s[l][i] >>> i);
					z_s[l][i+1] <= z_s[l][i] - AT;
				end else begin
					x_s[l][i+1] <= x_s[l][i] + (y_s[l][i] >>> i);
					y_s[l][i+1] <= y_s[l][i] - (x_s[l][i] >>> i);
					z_s[l][i+1] <= z_s[l][i] + AT;
				end
			end
		end

		always_ff @(posedge clk) begin
			cos_s[l] <= neg_s[l][STAGES] ? -x_s[l][STAGES] : x_s[l][STAGES];
			sin_s[l] <= neg_s[l][STAGES] ? -y_s[l][STAGES] : y_s[l][STAGES];
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		for (int i = 0; i <= STAGES; i++) begin
			side_s[i+1] <= side_s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STAGES + 1; i++) begin
				v_s[i] <= 1'b0;
			end
		end else begin
			v_s[0] <= in_v;
			for (int i = 0; i <= STAGES; i++) begin
				v_s[i+1] <= v_s[i];
			end
		end
	end

	assign out_v = v_s[STAGES+1];
	assign side_out = side_s[STAGES+1];
	assign a_cos = cos_s[0];
	assign a_sin = sin_s[0];
	assign b_cos = cos_s[1];
	assign b_sin = sin_s[1];
endmodule

FILE: rtl/gsr_ecef.sv
// ----------------------------------------------------------------------------
// gsr_ecef
// geodetic position to earth-centred coordinates in q8 cm
// ----------------------------------------------------------------------------
module gsr_ecef import gsr_pkg::*; #(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_v,
	input  logic [30:0] lat,
	input  logic [31:0] lon,
	input  logic [24:0] h,
	output logic        out_v,
	output pos_t        pos
);
	logic signed [63:0] lat_z, lon_z, cl, sl, co, so;
	logic [24:0] h_c;
	logic v_c, v_m1, v_m2, v_m3, v_m4, v_m5;
	trig_t tr_c, tr_m1, tr_m2, tr_m3;
	nt_t nt_in, nt_m4;
	logic [63:0] sl_mag, s2a, s2, d, n, pm, hs, r, zc, rc, zz, px, py;
	logic [127:0] cs_m5;
	logic [63:0] zz_m6;

	logic nv_v [NEWTON_STEPS+1];
	logic [63:0] nv [NEWTON_STEPS+1];
	logic [63:0] ny [NEWTON_STEPS+1];
	trig_t ntr [NEWTON_STEPS+1];

	assign lat_z = {{4{lat[30]}}, lat, 29'b0};
	assign lon_z = {{3{lon[31]}}, lon, 29'b0};

	gsr_sincos #(.STAGES(STAGES), .SW(25)) u_sc (
		.clk(clk), .arst_n(arst_n), .in_v(in_v), .a_z(lat_z), .b_z(lon_z), .side_in(h),
		.out_v(v_c), .a_cos(cl), .a_sin(sl), .b_cos(co), .b_sin(so), .side_out(h_c)
	);

	assign tr_c = '{cl: cl, sl: sl, co: co, so: so, h: h_c};
	assign sl_mag = sl[63] ? 64'(-sl) : sl;

	gsr_mul #(.SHIFT(60), .SGN(1'b0), .SW($bits(trig_t))) u_m1 (
		.clk(clk), .arst_n(arst_n), .in_v(v_c), .x(sl_mag), .y(sl_mag), .side_in(tr_c),
		.out_v(v_m1), .p(s2a), .side_out(tr_m1)
	);

	gsr_mul #(.SHIFT(40), .SGN(1'b0), .SW($bits(trig_t))) u_m2 (
		.clk(clk), .arst_n(arst_n), .in_v(v_m1), .x(ECC2_Q40), .y(s2a), .side_in(tr_m1),
		.out_v(v_m2), .p(s2), .side_out(tr_m2)
	);

	assign d = (s2 >= ONE_Q60) ? 64'd0 : ONE_Q60 - s2;
	assign nv_v[0] = v_m2;
	assign nv[0] = d;
	assign ny[0] = ONE_Q60;
	assign ntr[0] = tr_m2;

	for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_newton
		nsd_t sd_in, sd_a, sd_b, sd_c;
		logic va, vb;
		logic [63:0] y2, gy, t;

		assign sd_in = '{tr: ntr[k], v: nv[k], y: ny[k]};

		gsr_mul #(.SHIFT(60), .SGN(1'b0), .SW($bits(nsd_t))) u_ma (
			.clk(clk), .arst_n(arst_n), .in_v(nv_v[k]), .x(ny[k]), .y(ny[k]),
			.side_in(sd_in), .out_v(va), .p(y2), .side_out(sd_a)
		);

		gsr_mul #(.SHIFT(60), .SGN(1'b0), .SW($bits(nsd_t))) u_mb (
			.clk(clk), .arst_n(arst_n), .in_v(va), .x(sd_a.v), .y(y2),
			.side_in(sd_a), .out_v(vb), .p(gy), .side_out(sd_b)
		);

		assign t = (gy >= THREE_Q60) ? 64'd0 : THREE_Q60 - gy;

		gsr_mul #(.SHIFT(61), .SGN(1'b0), .SW($bits(nsd_t))) u_mc (
			.clk(clk), .arst_n(arst_n), .in_v(vb), .x(sd_b.y), .y(t),
			.side_in(sd_b), .out_v(nv_v[k+1]), .p(ny[k+1]), .side_out(sd_c)
		);

		assign nv[k+1] = sd_c.v;
		assign ntr[k+1] = sd_c.tr;
	end

	gsr_mul #(.SHIFT(52), .SGN(1'b1), .SW($bits(trig_t))) u_m3 (
		.clk(clk), .arst_n(arst_n), .in_v(nv_v[NEWTON_STEPS]), .x(SEMI_MAJOR_CM),
		.y(ny[NEWTON_STEPS]), .side_in(ntr[NEWTON_STEPS]),
		.out_v(v_m3), .p(n), .side_out(tr_m3)
	);

	assign nt_in = '{tr: tr_m3, n: n};

	gsr_mul #(.SHIFT(40), .SGN(1'b1), .SW($bits(nt_t))) u_m4 (
		.clk(clk), .arst_n(arst_n), .in_v(v_m3), .x(n), .y(ECC2_Q40), .side_in(nt_in),
		.out_v(v_m4), .p(pm), .side_out(nt_m4)
	);

	assign hs = {{31{nt_m4.tr.h[24]}}, nt_m4.tr.h, 8'b0};
	assign r = nt_m4.n + hs;
	assign zc = nt_m4.n - pm + hs;

	gsr_mul #(.SHIFT(60), .SGN(1'b1), .SW(128)) u_m5a (
		.clk(clk), .arst_n(arst_n), .in_v(v_m4), .x(r), .y(nt_m4.tr.cl),
		.side_in({nt_m4.tr.co, nt_m4.tr.so}), .out_v(v_m5), .p(rc), .side_out(cs_m5)
	);

	gsr_mul #(.SHIFT(60), .SGN(1'b1), .SW(1)) u_m5b (
		.clk(clk), .arst_n(arst_n), .in_v(v_m4), .x(zc), .y(nt_m4.tr.sl),
		.side_in(1'b0), .out_v(), .p(zz), .side_out()
	);

	gsr_mul #(.SHIFT(60), .SGN(1'b1), .SW(64)) u_m6a (
		.clk(clk), .arst_n(arst_n), .in_v(v_m5), .x(rc), .y(cs_m5[127:64]),
		.side_in(zz), .out_v(out_v), .p(px), .side_out(zz_m6)
	);

	gsr_mul #(.SHIFT(60), .SGN(1'b1), .SW(1)) u_m6b (
		.clk(clk), .arst_n(arst_n), .in_v(v_m5), .x(rc), .y(cs_m5[63:0]),
		.side_in(1'b0), .out_v(), .p(py), .side_out()
	);

	assign pos[0] = px;
	assign pos[1] = py;
	assign pos[2] = zz_m6;
endmodule

FILE: rtl/gsr_dist.sv
// ----------------------------------------------------------------------------
// gsr_dist
// coordinate differences, sum of squares and pipelined bitwise square root
// ----------------------------------------------------------------------------
module gsr_dist import gsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_v,
	input  pos_t        pa,
	input  pos_t        pb,
	output logic        out_v,
	output logic [30:0] range_cm
);
	logic [31:0] m_s1 [3];
	logic [63:0] sq_s2 [3];
	logic [65:0] tot;
	logic [63:0] rn_s [33];
	logic [63:0] rr_s [33];
	logic v_s [36];
	logic [32:0] cm;
	logic [30:0] range_s;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [63:0] df, dq;
		logic [63:0] mg;
		assign df = pa[a] - pb[a] + 64'sd64;
		assign dq = df >>> 7;
		assign mg = dq[63] ? 64'(-dq) : dq;
		always_ff @(posedge clk) begin
			m_s1[a] <= (|mg[63:32]) ? 32'hFFFF_FFFF : mg[31:0];
			sq_s2[a] <= m_s1[a] * m_s1[a];
		end
	end

	assign tot = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};

	always_ff @(posedge clk) begin
		rn_s[0] <= (|tot[65:64]) ? '1 : tot[63:0];
		rr_s[0] <= '0;
	end

	for (genvar j = 0; j < 32; j++) begin : g_root
		localparam logic [64:0] BIT = 65'd1 << (62 - 2 * j);
		logic [64:0] trial;
		assign trial = {1'b0, rr_s[j]} + BIT;
		always_ff @(posedge clk) begin
			if ({1'b0, rn_s[j]} >= trial) begin
				rn_s[j+1] <= rn_s[j] - trial[63:0];
				rr_s[j+1] <= (rr_s[j] >> 1) + BIT[63:0];
			end else begin
				rn_s[j+1] <= rn_s[j];
				rr_s[j+1] <= rr_s[j] >> 1;
			end
		end
	end

	assign cm = ({1'b0, rr_s[32][31:0]} + 33'd1) >> 1;

	always_ff @(posedge clk) begin
		range_s <= (cm > RANGE_TOP) ? RANGE_TOP[30:0] : cm[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 36; i++) begin
				v_s[i] <= 1'b0;
			end
		end else begin
			v_s[0] <= in_v;
			for (int i = 0; i < 35; i++) begin
				v_s[i+1] <= v_s[i];
			end
		end
	end

	assign out_v = v_s[35];
	assign range_cm = range_s;
endmodule

FILE: rtl/geodetic_slant_range.sv
// ----------------------------------------------------------------------------
// geodetic_slant_range
// wgs84 slant range between two geodetic positions, fully pipelined
// throughput: one word per cycle; busy stays low, every start is taken
// the cordic chain, 24 chained multiplies and a 32-step root set the depth
// reset: arst_n clears all valid bits at once; data registers are not reset
// ----------------------------------------------------------------------------
module geodetic_slant_range import gsr_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [30:0] own_lat,
	input  logic [31:0] own_lon,
	input  logic [24:0] own_height,
	input  logic [30:0] target_lat,
	input  logic [31:0] target_lon,
	input  logic [24:0] target_height,
	output logic        done,
	output logic [30:0] range_cm
);
	logic own_v;
	pos_t pa, pb;

	assign busy = 1'b0;

	gsr_ecef #(.STAGES(CORDIC_STAGES)) u_own (
		.clk(clk), .arst_n(arst_n), .in_v(start), .lat(own_lat), .lon(own_lon),
		.h(own_height), .out_v(own_v), .pos(pa)
	);

	gsr_ecef #(.STAGES(CORDIC_STAGES)) u_tgt (
		.clk(clk), .arst_n(arst_n), .in_v(start), .lat(target_lat), .lon(target_lon),
		.h(target_height), .out_v(), .pos(pb)
	);

	gsr_dist u_dist (
		.clk(clk), .arst_n(arst_n), .in_v(own_v), .pa(pa), .pb(pb),
		.out_v(done), .range_cm(range_cm)
	);
endmodule

FILE: rtl/gsr_checker.sv
// ----------------------------------------------------------------------------
// gsr_checker
// port-level checks on timing and range of the slant range block
// ----------------------------------------------------------------------------
`include "geodetic_slant_range_defines.svh"

module gsr_checker import gsr_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [30:0] range_cm
);
	localparam int LAT = gsr_latency(CORDIC_STAGES);

	`GSR_NEVER(a_never_busy, busy)
	`GSR_ASSERT(a_range_top, done |-> range_cm <= RANGE_TOP[30:0])
	`GSR_ASSERT(a_done_has_start, done |-> $past(start, LAT))
	`GSR_ASSERT(a_start_gives_done, (start && !busy) |-> ##LAT done)
endmodule

bind geodetic_slant_range gsr_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_gsr_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.range_cm(range_cm)
);
